// ----- design/wlrs_pkg.sv -----
// Shared types, constants and datapath operation codes of the record store.
// No dependencies.
`timescale 1ns / 1ps

package wlrs_pkg;

   localparam int ChunkSlots     = 16;
   localparam int RecordBytesMax = 32;
   localparam int MemoryBytes    = 1024;

   localparam logic [7:0] ErasedByte = 8'hff;
   localparam logic [7:0] ValidMask  = 8'h7f;
   localparam logic [7:0] InvalidBit = 8'h80;

   localparam logic [1:0] KIND_DEFINE = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOREC  = 2'd1;
   localparam logic [1:0] ST_BADID  = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_CLEAR     = 4'd1;
   localparam logic [3:0] OP_LATCH     = 4'd2;
   localparam logic [3:0] OP_DEFINE    = 4'd3;
   localparam logic [3:0] OP_BADID     = 4'd4;
   localparam logic [3:0] OP_PUSH      = 4'd5;
   localparam logic [3:0] OP_ACK_WR    = 4'd6;
   localparam logic [3:0] OP_SCAN_RD   = 4'd7;
   localparam logic [3:0] OP_SCAN_NEXT = 4'd8;
   localparam logic [3:0] OP_USE_START = 4'd9;
   localparam logic [3:0] OP_BYTE_RD   = 4'd10;
   localparam logic [3:0] OP_CMP_NEXT  = 4'd11;
   localparam logic [3:0] OP_MARK      = 4'd12;
   localparam logic [3:0] OP_PEND_RD   = 4'd13;
   localparam logic [3:0] OP_WR_BYTE   = 4'd14;
   localparam logic [3:0] OP_NOREC     = 4'd15;
   // read emit shares the byte read path; it is its own code below
   localparam logic [4:0] OP_RD_EMIT   = 5'd16;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] chunk_id;
      logic [5:0] record_size;
      logic [9:0] spare_bytes;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
      logic [4:0] byte_position;
      logic [3:0] assigned_id;
      logic       written;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       clr_done;
      logic       cid_bad;
      logic       commit;
      logic       scan_fits;
      logic       scan_valid;
      logic       cmp_diff;
      logic       i_last;
   } stat_type;

endpackage

// ----- design/wear_leveled_record_store_core.sv -----
// Top level of the wear-leveled record store: sequencer plus datapath.
// Depends on wlrs_pkg, wlrs_ctrl and wlrs_datapath.
`timescale 1ns / 1ps

//  channel   ports                           handshake
//  request   start, busy, req_payload        taken when start && !busy
//  result    rsp_strobe, rsp_payload         one strobe per result, no stall
//  csr       csr_valid, csr_ready, csr_wdata taken when valid && ready
//
// After reset the storage is erased with busy high. A define or a rejected
// request is answered from the decode state; a write that does not complete
// its record is acknowledged. A commit scans the slots, compares the bytes,
// rewrites the record if they differ and gives the result; a read scans the
// slots and returns the bytes one by one. Each result appears in the cycle
// after its operation. Results cannot be held off.
module wear_leveled_record_store_core #(
   parameter int MEMORY_BYTES = wlrs_pkg::MemoryBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wlrs_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output wlrs_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [9:0]        csr_wdata
);

   wlrs_pkg::cmd_type  cmd;
   wlrs_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   wlrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   wlrs_datapath #(
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_payload),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp_payload)
   );

endmodule

// ----- design/wlrs_ctrl.sv -----
// Sequencer of the record store: clearing pass, define, commit scan and read.
// Depends on wlrs_pkg.
`timescale 1ns / 1ps

module wlrs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  wlrs_pkg::stat_type stat,
   output wlrs_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOOK   = 4'd2;
   localparam logic [3:0] S_WDEC   = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_SCHK   = 4'd5;
   localparam logic [3:0] S_CMP    = 4'd6;
   localparam logic [3:0] S_CCHK   = 4'd7;
   localparam logic [3:0] S_WRISS  = 4'd8;
   localparam logic [3:0] S_WRDO   = 4'd9;
   localparam logic [3:0] S_WACK   = 4'd10;
   localparam logic [3:0] S_RDISS  = 4'd11;
   localparam logic [3:0] S_RDEMIT = 4'd12;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = {1'b0, wlrs_pkg::OP_NONE};
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = {1'b0, wlrs_pkg::OP_CLEAR};
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = {1'b0, wlrs_pkg::OP_LATCH};
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_IDLE;
            if (stat.kind == wlrs_pkg::KIND_DEFINE) begin
               cmd.op = {1'b0, wlrs_pkg::OP_DEFINE};
            end else if (stat.kind == wlrs_pkg::KIND_WRITE ||
                         stat.kind == wlrs_pkg::KIND_READ) begin
               if (stat.cid_bad) begin
                  cmd.op = {1'b0, wlrs_pkg::OP_BADID};
               end else if (stat.kind == wlrs_pkg::KIND_WRITE) begin
                  cmd.op   = {1'b0, wlrs_pkg::OP_PUSH};
                  state_in = S_WDEC;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_WDEC: begin
            if (stat.commit) begin
               state_in = S_SCAN;
            end else begin
               cmd.op   = {1'b0, wlrs_pkg::OP_ACK_WR};
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_fits) begin
               cmd.op   = {1'b0, wlrs_pkg::OP_SCAN_RD};
               state_in = S_SCHK;
            end else if (stat.kind == wlrs_pkg::KIND_WRITE) begin
               cmd.op   = {1'b0, wlrs_pkg::OP_USE_START};
               state_in = S_CMP;
            end else begin
               cmd.op   = {1'b0, wlrs_pkg::OP_NOREC};
               state_in = S_IDLE;
            end
         end
         S_SCHK: begin
            if (stat.scan_valid) begin
               state_in = (stat.kind == wlrs_pkg::KIND_WRITE) ? S_CMP : S_RDISS;
            end else begin
               cmd.op   = {1'b0, wlrs_pkg::OP_SCAN_NEXT};
               state_in = S_SCAN;
            end
         end
         S_CMP: begin
            cmd.op   = {1'b0, wlrs_pkg::OP_BYTE_RD};
            state_in = S_CCHK;
         end
         S_CCHK: begin
            if (stat.cmp_diff) begin
               cmd.op   = {1'b0, wlrs_pkg::OP_MARK};
               state_in = S_WRISS;
            end else if (stat.i_last) begin
               cmd.op   = {1'b0, wlrs_pkg::OP_ACK_WR};
               state_in = S_IDLE;
            end else begin
               cmd.op   = {1'b0, wlrs_pkg::OP_CMP_NEXT};
               state_in = S_CMP;
            end
         end
         S_WRISS: begin
            cmd.op   = {1'b0, wlrs_pkg::OP_PEND_RD};
            state_in = S_WRDO;
         end
         S_WRDO: begin
            cmd.op   = {1'b0, wlrs_pkg::OP_WR_BYTE};
            state_in = stat.i_last ? S_WACK : S_WRISS;
         end
         S_WACK: begin
            cmd.op   = {1'b0, wlrs_pkg::OP_ACK_WR};
            state_in = S_IDLE;
         end
         S_RDISS: begin
            cmd.op   = {1'b0, wlrs_pkg::OP_BYTE_RD};
            state_in = S_RDEMIT;
         end
         S_RDEMIT: begin
            cmd.op   = wlrs_pkg::OP_RD_EMIT;
            state_in = stat.i_last ? S_IDLE : S_RDISS;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// ----- design/wlrs_datapath.sv -----
// Storage array, chunk table, pending record buffer and result register.
// Executes one operation code per cycle from wlrs_ctrl. Depends on wlrs_pkg.
`timescale 1ns / 1ps

module wlrs_datapath #(
   parameter int MEMORY_BYTES = wlrs_pkg::MemoryBytes
) (
   input  logic               clock,
   input  logic               reset,
   input  wlrs_pkg::req_type  req,
   input  logic               csr_we,
   input  logic [9:0]         csr_wdata,
   input  wlrs_pkg::cmd_type  cmd,
   output wlrs_pkg::stat_type stat,
   output logic               rsp_valid,
   output wlrs_pkg::rsp_type  rsp
);

   localparam int AW = $clog2(MEMORY_BYTES);
   localparam int XW = ((AW > 10) ? AW : 10) + 2;
   localparam int CS = wlrs_pkg::ChunkSlots;
   localparam int RM = wlrs_pkg::RecordBytesMax;
   localparam int PW = $clog2(RM);
   localparam int FW = $clog2(RM + 1);
   localparam int CW = $clog2(CS + 1);
   localparam int TW = $clog2(CS);

   logic [7:0]    mem [MEMORY_BYTES];
   logic [7:0]    pend [RM];
   logic [XW-1:0] tab_start [CS];
   logic [5:0]    tab_size [CS];
   logic [XW-1:0] tab_end [CS];

   logic [9:0]    base_ff;
   logic [CW-1:0] count_ff;
   logic [XW-1:0] next_ff;
   logic [FW-1:0] fill_ff;
   logic [AW-1:0] clr_ff;
   logic          commit_ff, wr_ff, rsp_valid_ff;
   logic          look_ff;
   wlrs_pkg::req_type req_ff;
   wlrs_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_in;
   logic [XW-1:0] s_ff, end_ff, a_ff;
   logic [5:0]    sz_ff;
   logic [PW-1:0] i_ff;
   logic [7:0]    mem_q, pend_q;

   logic [XW-1:0] ai, def_s, def_len, nxt;
   logic [FW-1:0] fill_new;
   logic [5:0]    look_size;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd, old_b, new_b;
   logic          i_zero;

   assign ai      = a_ff + XW'(i_ff);
   assign i_zero  = (i_ff == '0);
   assign def_s   = (count_ff == '0) ? XW'(base_ff) : next_ff;
   assign def_len = XW'(req_ff.record_size) + XW'(req_ff.spare_bytes);
   assign nxt     = a_ff + XW'(sz_ff);
   assign fill_new = fill_ff + FW'(1);
   // record size of the addressed chunk, valid while the request is decoded
   assign look_size = tab_size[req_ff.chunk_id[TW-1:0]];
   assign old_b   = i_zero ? (mem_q & wlrs_pkg::ValidMask) : mem_q;
   assign new_b   = i_zero ? (pend_q & wlrs_pkg::ValidMask) : pend_q;

   assign stat.kind       = req_ff.kind;
   assign stat.clr_done   = (clr_ff == AW'(MEMORY_BYTES - 1));
   assign stat.cid_bad    = (CW'(req_ff.chunk_id) >= count_ff);
   assign stat.commit     = commit_ff;
   assign stat.scan_fits  = (nxt <= end_ff);
   assign stat.scan_valid = ((mem_q & wlrs_pkg::InvalidBit) == 8'h00);
   assign stat.cmp_diff   = (old_b != new_b);
   assign stat.i_last     = ((6'(i_ff) + 6'd1) == sz_ff);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = a_ff[AW-1:0];
      mem_wd = wlrs_pkg::ErasedByte;
      mem_ra = ai[AW-1:0];
      case (cmd.op)
         {1'b0, wlrs_pkg::OP_CLEAR}: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
         end
         {1'b0, wlrs_pkg::OP_MARK}: mem_we = 1'b1;
         {1'b0, wlrs_pkg::OP_WR_BYTE}: begin
            mem_we = 1'b1;
            mem_wa = ai[AW-1:0];
            mem_wd = new_b;
         end
         {1'b0, wlrs_pkg::OP_SCAN_RD}: mem_ra = a_ff[AW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == {1'b0, wlrs_pkg::OP_PUSH} && fill_ff < FW'(RM))
         pend[fill_ff[PW-1:0]] <= req_ff.byte_value;
      pend_q <= pend[i_ff];
   end

   // chunk table and per-item work registers: payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.op == {1'b0, wlrs_pkg::OP_DEFINE} && count_ff < CW'(CS) &&
          req_ff.record_size != 6'd0 && req_ff.record_size <= 6'(RM) &&
          def_s + def_len <= XW'(MEMORY_BYTES)) begin
         tab_start[count_ff[TW-1:0]] <= def_s;
         tab_size[count_ff[TW-1:0]]  <= req_ff.record_size;
         tab_end[count_ff[TW-1:0]]   <= def_s + def_len;
      end
      if (cmd.op == {1'b0, wlrs_pkg::OP_LATCH}) begin
         req_ff <= req;
         i_ff   <= '0;
      end
      // slot pointer starts at the region of the addressed chunk
      if (look_ff) a_ff <= tab_start[req_ff.chunk_id[TW-1:0]];
      case (cmd.op)
         {1'b0, wlrs_pkg::OP_SCAN_NEXT}: a_ff <= nxt;
         {1'b0, wlrs_pkg::OP_USE_START}: a_ff <= s_ff;
         {1'b0, wlrs_pkg::OP_CMP_NEXT},
         {1'b0, wlrs_pkg::OP_WR_BYTE},
         wlrs_pkg::OP_RD_EMIT: i_ff <= i_ff + PW'(1);
         {1'b0, wlrs_pkg::OP_MARK}: begin
            a_ff <= (nxt + XW'(sz_ff) > end_ff) ? s_ff : nxt;
            i_ff <= '0;
         end
         default: ;
      endcase
   end

   // region of the addressed chunk, picked up from the latched request
   always_ff @(posedge clock) begin
      if (reset) look_ff <= 1'b0;
      else       look_ff <= (cmd.op == {1'b0, wlrs_pkg::OP_LATCH});
   end

   always_ff @(posedge clock) begin
      if (look_ff) begin
         s_ff   <= tab_start[req_ff.chunk_id[TW-1:0]];
         sz_ff  <= look_size;
         end_ff <= tab_end[req_ff.chunk_id[TW-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in = 1'b1;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      case (cmd.op)
         {1'b0, wlrs_pkg::OP_DEFINE}: begin
            if (count_ff >= CW'(CS) || req_ff.record_size == 6'd0 ||
                req_ff.record_size > 6'(RM)) begin
               rsp_in.status = wlrs_pkg::ST_BADID;
            end else if (def_s + def_len > XW'(MEMORY_BYTES)) begin
               rsp_in.status = wlrs_pkg::ST_RANGE;
            end else begin
               rsp_in.status      = wlrs_pkg::ST_OK;
               rsp_in.assigned_id = 4'(count_ff);
            end
         end
         {1'b0, wlrs_pkg::OP_BADID}: rsp_in.status = wlrs_pkg::ST_BADID;
         {1'b0, wlrs_pkg::OP_NOREC}: rsp_in.status = wlrs_pkg::ST_NOREC;
         {1'b0, wlrs_pkg::OP_ACK_WR}: rsp_in.written = wr_ff;
         wlrs_pkg::OP_RD_EMIT: begin
            rsp_in.data_byte     = old_b;
            rsp_in.byte_position = 5'(i_ff);
            rsp_in.last          = stat.i_last;
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         base_ff      <= '0;
         count_ff     <= '0;
         next_ff      <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         commit_ff    <= 1'b0;
         wr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) base_ff <= csr_wdata;
         case (cmd.op)
            {1'b0, wlrs_pkg::OP_CLEAR}: clr_ff <= clr_ff + AW'(1);
            {1'b0, wlrs_pkg::OP_LATCH}: wr_ff <= 1'b0;
            {1'b0, wlrs_pkg::OP_MARK}:  wr_ff <= 1'b1;
            {1'b0, wlrs_pkg::OP_PUSH}: begin
               commit_ff <= (6'(fill_new) >= look_size);
               fill_ff   <= (6'(fill_new) >= look_size) ? '0 : fill_new;
            end
            {1'b0, wlrs_pkg::OP_DEFINE}: begin
               if (count_ff < CW'(CS) && req_ff.record_size != 6'd0 &&
                   req_ff.record_size <= 6'(RM) &&
                   def_s + def_len <= XW'(MEMORY_BYTES)) begin
                  count_ff <= count_ff + CW'(1);
                  next_ff  <= def_s + def_len;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(RM))
      else $error("pending fill past buffer");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CS))
      else $error("chunk count past table");
   a_rd_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == wlrs_pkg::OP_RD_EMIT && stat.i_last) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("read run did not end with last");
`endif

endmodule
